/* design/assert_macros.svh */
// assert_macros.svh: assertion helpers for the scan checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, off while in reset
`define ASM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("adc scan check failed");
// same-cycle implication
`define ASM_IMPLY(label, cond, expr) \
	`ASM_ASSERT(label, (cond) |-> (expr))
`endif

/* design/asma_pkg.sv */
// asma_pkg: command codes, field widths and the word types passed between
// the scan front end, the queues and the window engine. No dependencies.
`default_nettype none
package asma_pkg;

	localparam int CHAN_W   = 3;
	localparam int SAMPLE_W = 12;
	localparam int MASK_W   = 8;
	localparam int APB_W    = 32;
	localparam int ADDR_W   = 3;

	localparam logic REG_MASK = 1'b0;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_CONV  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [CHAN_W-1:0]   chan;
		logic [CHAN_W-1:0]   nxt;
		logic [SAMPLE_W-1:0] sample;
		logic [CHAN_W-1:0]   rch;
		logic                rd_en;
	} job_t;

	typedef struct packed {
		logic                start;
		logic [CHAN_W-1:0]   nxt;
		logic [SAMPLE_W-1:0] value;
		logic [CHAN_W-1:0]   vch;
	} res_t;

endpackage
`default_nettype wire

/* design/asma_fifo.sv */
// asma_fifo: two-entry queue for one word of WIDTH bits.
// Stand-alone; used for the job queue and the result queue.
`default_nettype none
module asma_fifo #(
	parameter int WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int DEPTH = 2;

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'(DEPTH));
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			cnt_q <= 2'(cnt_q + {1'b0, do_push} - {1'b0, do_pop});
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			buf_q[wr_q] <= wdata;
	end

endmodule
`default_nettype wire

/* design/asma_front.sv */
// asma_front: enable register on the APB port, scan pointer and
// next-channel search; turns each accepted word into a job. Uses asma_pkg.
`default_nettype none
module asma_front #(
	parameter int NUM_CHANNELS,
	parameter int SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [asma_pkg::ADDR_W-1:0]         paddr,
	input  logic [asma_pkg::APB_W-1:0]          pwdata,
	output logic [asma_pkg::APB_W-1:0]          prdata,
	input  logic                                accept,
	input  logic [1:0]                          command,
	input  logic [asma_pkg::SAMPLE_W-1:0]       sample,
	input  logic [asma_pkg::CHAN_W-1:0]         read_channel,
	output asma_pkg::job_t                      job
);

	localparam int CW  = asma_pkg::CHAN_W;
	localparam int NCH = (NUM_CHANNELS < asma_pkg::MASK_W) ? NUM_CHANNELS : asma_pkg::MASK_W;
	localparam int SB  = (SAMPLE_BITS < asma_pkg::SAMPLE_W) ? SAMPLE_BITS : asma_pkg::SAMPLE_W;

	logic [asma_pkg::MASK_W-1:0] mask_q;
	logic [CW-1:0]               cur_q;
	logic [CW-1:0]               cur_d;
	logic [NCH-1:0]              en;
	logic                        reg_idx;
	logic                        wr;
	logic                        rd_ok;

	function automatic logic [CW-1:0] search_from(input logic [NCH-1:0] ena,
			input logic [CW:0] first);
		logic [CW-1:0] hit;
		hit = '0;
		for (int i = NCH - 1; i >= 0; i--)
			if (ena[i])
				hit = CW'(i);
		for (int i = NCH - 1; i >= 0; i--)
			if (ena[i] && ((CW + 1)'(i) >= first))
				hit = CW'(i);
		return hit;
	endfunction

	assign en      = mask_q[NCH-1:0];
	assign reg_idx = paddr[asma_pkg::ADDR_W-1];
	assign wr      = psel && penable && pwrite;
	assign prdata  = (reg_idx == asma_pkg::REG_MASK) ? asma_pkg::APB_W'(mask_q) : '0;
	assign rd_ok   = ({1'b0, read_channel} < (CW + 1)'(NCH)) && mask_q[read_channel];

	always_comb begin
		job   = '0;
		cur_d = cur_q;
		job.cmd = asma_pkg::CMD_READ;
		case (asma_pkg::cmd_t'(command))
			asma_pkg::CMD_START: begin
				cur_d   = search_from(en, '0);
				job.cmd = asma_pkg::CMD_START;
				job.nxt = cur_d;
			end
			asma_pkg::CMD_CONV: begin
				cur_d      = search_from(en, {1'b0, cur_q} + (CW + 1)'(1));
				job.cmd    = asma_pkg::CMD_CONV;
				job.chan   = cur_q;
				job.nxt    = cur_d;
				job.sample = asma_pkg::SAMPLE_W'(sample[SB-1:0]);
			end
			asma_pkg::CMD_READ: begin
				job.nxt   = cur_q;
				job.rch   = read_channel;
				job.rd_en = rd_ok;
			end
			default: begin
				// unused code: a disabled read of channel 0 gives an all-zero word
				job.cmd = asma_pkg::CMD_READ;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			cur_q  <= '0;
		end else begin
			if (wr && (reg_idx == asma_pkg::REG_MASK))
				mask_q <= pwdata[asma_pkg::MASK_W-1:0];
			if (accept)
				cur_q <= cur_d;
		end
	end

endmodule
`default_nettype wire

/* design/asma_back.sv */
// asma_back: per-channel ring windows, running sums and stored means.
// Window read, sum update, then mean by reciprocal multiply. Uses asma_pkg.
`default_nettype none
module asma_back #(
	parameter int NUM_CHANNELS,
	parameter int WINDOW,
	parameter int SAMPLE_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  asma_pkg::job_t job,
	output logic           job_pop,
	input  logic           res_full,
	output logic           res_push,
	output asma_pkg::res_t res
);

	localparam int NCH    = (NUM_CHANNELS < asma_pkg::MASK_W) ? NUM_CHANNELS : asma_pkg::MASK_W;
	localparam int CIW    = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int LOG_W  = $clog2(WINDOW);
	localparam int SB     = (SAMPLE_BITS < asma_pkg::SAMPLE_W) ? SAMPLE_BITS : asma_pkg::SAMPLE_W;
	localparam int SUM_W  = SB + LOG_W;
	localparam int SHIFT  = SUM_W + LOG_W;
	localparam int MUL_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam logic [MUL_W-1:0] RECIP =
		MUL_W'(((64'd1 << SHIFT) / 64'(WINDOW)) + 64'd1);
	localparam logic [PW-1:0] LAST = PW'(WINDOW - 1);

	logic [PW-1:0]    ptr_q [NCH];
	logic [NCH-1:0]   wrap_q;
	logic [SUM_W-1:0] sum_q [NCH];
	logic [SB-1:0]    avg_q [NCH];
	logic [SB-1:0]    win_mem_q [NCH][WINDOW];

	asma_pkg::job_t   job_s1;
	asma_pkg::job_t   job_s2;
	logic             v_s1;
	logic             v_s2;
	logic [PW-1:0]    ptr_s1;
	logic             wrap_s1;
	logic [SB-1:0]    rd_s1;
	logic             fwd_s1;
	logic [SB-1:0]    fwd_data_s1;
	logic [SUM_W-1:0] sum_s2;

	logic             issue;
	logic             s1_done;
	logic             s2_done;
	logic             s1_ready;
	logic             s2_ready;
	logic             conv_in;
	logic             conv_s1;
	logic             conv_s2;
	logic [CIW-1:0]   jc;
	logic [PW-1:0]    jp;
	logic [CIW-1:0]   c_s1;
	logic [CIW-1:0]   c_s2;
	logic [CIW-1:0]   r_s2;
	logic [SB-1:0]    smp_s1;
	logic [SB-1:0]    old_s1;
	logic [SUM_W-1:0] sum_new_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [SB-1:0]    mean_s2;

	assign s2_ready = !v_s2 || !res_full;
	assign s1_ready = !v_s1 || s2_ready;
	assign issue    = job_valid && s1_ready;
	assign s1_done  = v_s1 && s2_ready;
	assign s2_done  = v_s2 && !res_full;
	assign job_pop  = issue;
	assign res_push = s2_done;

	assign conv_in = (job.cmd == asma_pkg::CMD_CONV);
	assign conv_s1 = (job_s1.cmd == asma_pkg::CMD_CONV);
	assign conv_s2 = (job_s2.cmd == asma_pkg::CMD_CONV);
	assign jc      = job.chan[CIW-1:0];
	assign jp      = ptr_q[jc];
	assign c_s1    = job_s1.chan[CIW-1:0];
	assign c_s2    = job_s2.chan[CIW-1:0];
	assign r_s2    = job_s2.rch[CIW-1:0];
	assign smp_s1  = job_s1.sample[SB-1:0];

	always_comb begin
		old_s1     = fwd_s1 ? fwd_data_s1 : (wrap_s1 ? rd_s1 : '0);
		sum_new_s1 = sum_q[c_s1] - SUM_W'(old_s1) + SUM_W'(smp_s1);
		prod_s2    = PROD_W'(sum_s2) * PROD_W'(RECIP);
		mean_s2    = prod_s2[SHIFT +: SB];
	end

	always_comb begin
		res = '0;
		case (job_s2.cmd)
			asma_pkg::CMD_START: begin
				res.start = 1'b1;
				res.nxt   = job_s2.nxt;
			end
			asma_pkg::CMD_CONV: begin
				res.start = 1'b1;
				res.nxt   = job_s2.nxt;
				res.value = asma_pkg::SAMPLE_W'(mean_s2);
				res.vch   = job_s2.chan;
			end
			asma_pkg::CMD_READ: begin
				res.nxt = job_s2.nxt;
				res.vch = job_s2.rch;
				if (job_s2.rd_en)
					res.value = asma_pkg::SAMPLE_W'(avg_q[r_s2]);
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			wrap_q <= '0;
			for (int i = 0; i < NCH; i++) begin
				ptr_q[i] <= '0;
				sum_q[i] <= '0;
				avg_q[i] <= '0;
			end
		end else begin
			if (issue)
				v_s1 <= 1'b1;
			else if (s1_done)
				v_s1 <= 1'b0;
			if (s1_done)
				v_s2 <= 1'b1;
			else if (s2_done)
				v_s2 <= 1'b0;
			if (issue && conv_in) begin
				if (jp == LAST) begin
					ptr_q[jc]  <= '0;
					wrap_q[jc] <= 1'b1;
				end else begin
					ptr_q[jc] <= PW'(jp + PW'(1));
				end
			end
			if (s1_done && conv_s1)
				sum_q[c_s1] <= sum_new_s1;
			if (s2_done && conv_s2)
				avg_q[c_s2] <= mean_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (issue)
			rd_s1 <= win_mem_q[jc][jp];
		if (s1_done && conv_s1)
			win_mem_q[c_s1][ptr_s1] <= smp_s1;
	end

	// bypass the word being written back in the same cycle as the read
	always_ff @(posedge clk) begin
		if (issue) begin
			job_s1      <= job;
			ptr_s1      <= jp;
			wrap_s1     <= wrap_q[jc];
			fwd_s1      <= s1_done && conv_s1 && (c_s1 == jc) && (ptr_s1 == jp);
			fwd_data_s1 <= smp_s1;
		end
		if (s1_done) begin
			job_s2 <= job_s1;
			sum_s2 <= sum_new_s1;
		end
	end

endmodule
`default_nettype wire

/* design/adc_scan_moving_average.sv */
// Round-robin converter scan with a moving average per channel. One command
// word is taken per clock while the job queue is not full, and one result
// word per command comes out, in order, through a two-entry job queue, the
// window memory's registered read, the running-sum update, the reciprocal
// multiply for the mean, then a two-entry result queue. The window
// memory has one read and one write port; the sum update and the multiply are
// each a stage of their own. Windows need no clearing pass after reset: a
// per-channel wrap flag makes unwritten entries read as zero.
`default_nettype none
module adc_scan_moving_average #(
	parameter int NUM_CHANNELS = 8,
	parameter int WINDOW       = 8,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [asma_pkg::ADDR_W-1:0]   paddr,
	input  logic [asma_pkg::APB_W-1:0]    pwdata,
	output logic [asma_pkg::APB_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    command,
	input  logic [asma_pkg::SAMPLE_W-1:0] sample,
	input  logic [asma_pkg::CHAN_W-1:0]   read_channel,
	output logic                          empty,
	input  logic                          pop,
	output logic                          start_issued,
	output logic [asma_pkg::CHAN_W-1:0]   next_channel,
	output logic [asma_pkg::SAMPLE_W-1:0] averaged_value,
	output logic [asma_pkg::CHAN_W-1:0]   value_channel
);

	asma_pkg::job_t front_job;
	asma_pkg::job_t back_job;
	asma_pkg::res_t back_res;
	asma_pkg::res_t out_res;
	logic           accept;
	logic           job_empty;
	logic           job_pop;
	logic           res_full;
	logic           res_push;

	assign pready = 1'b1;
	assign accept = push && !full;

	assign start_issued   = out_res.start;
	assign next_channel   = out_res.nxt;
	assign averaged_value = out_res.value;
	assign value_channel  = out_res.vch;

	asma_front #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.accept      (accept),
		.command     (command),
		.sample      (sample),
		.read_channel(read_channel),
		.job         (front_job)
	);

	asma_fifo #(
		.WIDTH($bits(asma_pkg::job_t))
	) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.wdata (front_job),
		.full  (full),
		.pop   (job_pop),
		.rdata (back_job),
		.empty (job_empty)
	);

	asma_back #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!job_empty),
		.job      (back_job),
		.job_pop  (job_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (back_res)
	);

	asma_fifo #(
		.WIDTH($bits(asma_pkg::res_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (back_res),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_res),
		.empty (empty)
	);

endmodule
`default_nettype wire

/* design/asma_checker.sv */
// asma_checker: port-level checks on the scan results against the enable
// mask seen on the APB port; bound to adc_scan_moving_average. Uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module asma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        start_issued,
	input logic [2:0]  next_channel,
	input logic [11:0] averaged_value,
	input logic [2:0]  value_channel
);

	logic [7:0] mask_q;
	logic [3:0] pend_q;
	logic       stale_q;
	logic       acc;
	logic       deq;
	logic       wr;
	logic       trust;

	assign acc   = push && !full;
	assign deq   = pop && !empty;
	assign wr    = psel && penable && pwrite && !paddr[2];
	assign trust = !empty && !stale_q;

	// drop trust in the shadow mask if it changes with words in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= 8'd0;
			pend_q  <= 4'd0;
			stale_q <= 1'b0;
		end else begin
			if (wr)
				mask_q <= pwdata[7:0];
			pend_q <= 4'(pend_q + {3'd0, acc} - {3'd0, deq});
			if (wr && (acc || (pend_q != 4'd0)))
				stale_q <= 1'b1;
			else if (pend_q == 4'd0)
				stale_q <= 1'b0;
		end
	end

	`ASM_IMPLY(a_start_on_enabled, trust && start_issued && (mask_q != 8'd0), mask_q[next_channel])
	`ASM_IMPLY(a_start_none_zero, trust && start_issued && (mask_q == 8'd0), next_channel == 3'd0)
	`ASM_IMPLY(a_read_disabled_zero, trust && !start_issued && !mask_q[value_channel], averaged_value == 12'd0)
	`ASM_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable({start_issued, next_channel, averaged_value, value_channel})))

endmodule

bind adc_scan_moving_average asma_checker u_asma_checker (.*);
`default_nettype wire
